>>> hw/rtl/page_framebuffer_draw_engine_core_defines.svh
// Assertion macros shared by the frame buffer draw engine RTL.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause (uses clk and rst_n of the module).
`define PFDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pfde_pkg.sv
// Shared codes and types of the frame buffer draw engine.
`timescale 1ns / 1ps

package pfde_pkg;

    localparam logic [2:0] MODE_WR_PIX  = 3'd0;
    localparam logic [2:0] MODE_RD_PIX  = 3'd1;
    localparam logic [2:0] MODE_FILL    = 3'd2;
    localparam logic [2:0] MODE_HLINE   = 3'd3;
    localparam logic [2:0] MODE_VLINE   = 3'd4;
    localparam logic [2:0] MODE_RD_BYTE = 3'd5;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_LAST = 3'b100
    } pfde_state_t;

endpackage

>>> hw/rtl/pfde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pfde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/page_framebuffer_draw_engine_core.sv
// Top level of the page-organized monochrome frame buffer draw engine.
`timescale 1ns / 1ps
`include "page_framebuffer_draw_engine_core_defines.svh"

// Monochrome frame buffer, one bit per pixel, WIDTH_PX columns by HEIGHT_PX
// rows, kept in pages of eight rows: pixel (x, y) sits in byte
// x + (y / 8) * WIDTH_PX, bit y % 8. Issue a command by raising start while
// busy is low; every command returns exactly one result word, shown for one
// cycle with done high once the command has passed its run and last states.
// The receiver cannot stall: sample the result ports on the cycle done is
// high. Timing is set by the frame RAM, which reads one byte and writes one
// byte per cycle: write pixel, read pixel and read byte touch at most one
// byte, unused modes none. A horizontal line touches one byte per drawn
// pixel and a vertical line one per touched page before the last state; an
// extra check that issues no byte is spent when the line has zero length or
// has left the screen (a vertical line clipped inside the last, partial
// page needs no such check). A fill writes all WIDTH_PX * ceil(HEIGHT_PX / 8)
// bytes. A line stops at the first pixel that leaves the screen, since
// every later one is off screen too. The next command is taken at the edge
// that raises done for the previous one. After reset the engine runs a
// clearing pass over all WIDTH_PX * ceil(HEIGHT_PX / 8) bytes and is busy
// meanwhile; no result word is produced for it.
module page_framebuffer_draw_engine_core #(
    parameter int WIDTH_PX  = 128,
    parameter int HEIGHT_PX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] mode,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic [7:0] length,
    input  logic       color,
    input  logic [9:0] byte_index,
    output logic       done,
    output logic       pixel_value,
    output logic [7:0] frame_byte,
    output logic       out_of_range
);

    import pfde_pkg::*;

    localparam int PAGES       = (HEIGHT_PX + 7) / 8;
    localparam int FRAME_BYTES = WIDTH_PX * PAGES;
    localparam int AW          = $clog2(FRAME_BYTES);

    // Control
    pfde_state_t state_reg, state_next;
    logic        silent_reg;      // clearing pass after reset: no result word
    logic [2:0]  mode_reg;
    logic        color_reg;
    logic [AW-1:0] faddr_reg, faddr_next;
    logic        oor_reg;

    // Command cursor (payload)
    logic [8:0]  cx_reg, cx_next;
    logic [8:0]  cy_reg, cy_next;
    logic [7:0]  rem_reg, rem_next;
    logic [9:0]  bidx_reg;

    // Write-back stage: the byte read last cycle is modified and written now
    logic          p_valid_reg;
    logic          p_write_reg;
    logic [AW-1:0] p_addr_reg;
    logic [7:0]    p_mask_reg;
    logic [2:0]    p_bit_reg;

    // Result word
    logic       done_reg;
    logic       pix_reg;
    logic [7:0] fbyte_reg;
    logic       oor_out_reg;

    // Element issued this cycle
    logic          e_valid;
    logic          e_write;
    logic [AW-1:0] e_addr;
    logic [7:0]    e_mask;
    logic          fin;
    logic          oor_set;

    logic          accept;
    logic          on_col;
    logic          on_row;
    logic [AW-1:0] pix_addr;
    logic [2:0]    lo;
    logic [3:0]    room;
    logic [3:0]    cnt;
    logic [7:0]    vmask;

    logic          wr_en;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    assign busy   = (state_reg == ST_RUN);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Element generator: at most one frame byte per cycle while in ST_RUN.
    // ------------------------------------------------------------------
    always_comb
    begin
        e_valid    = 1'b0;
        e_write    = 1'b0;
        e_addr     = '0;
        e_mask     = BYTE_ZEROS;
        fin        = 1'b0;
        oor_set    = 1'b0;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rem_next   = rem_reg;
        faddr_next = faddr_reg;
        vmask      = BYTE_ZEROS;

        on_col   = 32'(cx_reg) < WIDTH_PX;
        on_row   = 32'(cy_reg) < HEIGHT_PX;
        pix_addr = AW'(32'(cx_reg) + 32'(cy_reg[8:3]) * WIDTH_PX);
        lo       = cy_reg[2:0];
        room     = 4'd8 - {1'b0, lo};
        cnt      = (rem_reg < {4'b0000, room}) ? rem_reg[3:0] : room;

        for (int b = 0; b < 8; b++)
        begin
            vmask[b] = (b >= int'(lo)) && (b < int'(lo) + int'(cnt))
                       && (32'({cy_reg[8:3], 3'b000}) + 32'(b) < HEIGHT_PX);
        end

        if (state_reg == ST_RUN)
        begin
            unique case (mode_reg)
                MODE_WR_PIX, MODE_RD_PIX, MODE_HLINE:
                begin
                    if (rem_reg == 8'd0)
                    begin
                        fin = 1'b1;
                    end
                    else if (!(on_col && on_row))
                    begin
                        oor_set = 1'b1;
                        fin     = 1'b1;
                    end
                    else
                    begin
                        e_valid  = 1'b1;
                        e_write  = (mode_reg != MODE_RD_PIX);
                        e_addr   = pix_addr;
                        e_mask   = 8'b0000_0001 << lo;
                        cx_next  = cx_reg + 9'd1;
                        rem_next = rem_reg - 8'd1;
                        fin      = (rem_reg == 8'd1);
                    end
                end
                MODE_VLINE:
                begin
                    if (rem_reg == 8'd0)
                    begin
                        fin = 1'b1;
                    end
                    else if (!(on_col && on_row))
                    begin
                        oor_set = 1'b1;
                        fin     = 1'b1;
                    end
                    else
                    begin
                        // one page per cycle, rows below the screen edge masked off
                        e_valid  = 1'b1;
                        e_write  = 1'b1;
                        e_addr   = pix_addr;
                        e_mask   = vmask;
                        cy_next  = cy_reg + {5'b00000, cnt};
                        rem_next = rem_reg - {4'b0000, cnt};
                        if (32'(cy_reg) + 32'(cnt) > HEIGHT_PX)
                        begin
                            oor_set = 1'b1;
                            fin     = 1'b1;
                        end
                        if (rem_reg == {4'b0000, cnt})
                        begin
                            fin = 1'b1;
                        end
                    end
                end
                MODE_RD_BYTE:
                begin
                    if (32'(bidx_reg) < FRAME_BYTES)
                    begin
                        e_valid = 1'b1;
                        e_addr  = AW'(bidx_reg);
                    end
                    else
                    begin
                        oor_set = 1'b1;
                    end
                    fin = 1'b1;
                end
                MODE_FILL:
                begin
                    e_valid    = 1'b1;
                    e_write    = 1'b1;
                    e_addr     = faddr_reg;
                    e_mask     = BYTE_ONES;
                    faddr_next = faddr_reg + AW'(1);
                    fin        = (faddr_reg == AW'(FRAME_BYTES - 1));
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fin)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = accept ? ST_RUN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts the clearing pass: a silent fill with black
            state_reg   <= ST_RUN;
            silent_reg  <= 1'b1;
            mode_reg    <= MODE_FILL;
            color_reg   <= 1'b0;
            faddr_reg   <= '0;
            oor_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= e_valid;
            done_reg    <= (state_reg == ST_LAST) && !silent_reg;
            if (state_reg == ST_LAST)
            begin
                silent_reg <= 1'b0;
            end
            if (accept)
            begin
                mode_reg  <= mode;
                color_reg <= color;
                faddr_reg <= '0;
                oor_reg   <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                faddr_reg <= faddr_next;
                if (oor_set)
                begin
                    oor_reg <= 1'b1;
                end
            end
        end
    end

    // Cursor and write-back payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg   <= {1'b0, x};
            cy_reg   <= {1'b0, y};
            rem_reg  <= (mode == MODE_WR_PIX || mode == MODE_RD_PIX) ? 8'd1 : length;
            bidx_reg <= byte_index;
        end
        else if (state_reg == ST_RUN)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            rem_reg <= rem_next;
        end
        p_write_reg <= e_write;
        p_addr_reg  <= e_addr;
        p_mask_reg  <= e_mask;
        p_bit_reg   <= lo;
    end

    // Result word: capture on the last cycle of a command
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LAST)
        begin
            pix_reg     <= (mode_reg == MODE_RD_PIX && p_valid_reg) ?
                           rd_data[p_bit_reg] : 1'b0;
            fbyte_reg   <= (mode_reg == MODE_RD_BYTE && p_valid_reg) ? rd_data : BYTE_ZEROS;
            oor_out_reg <= oor_reg;
        end
    end

    assign done         = done_reg;
    assign pixel_value  = pix_reg;
    assign frame_byte   = fbyte_reg;
    assign out_of_range = oor_out_reg;

    // ------------------------------------------------------------------
    // Frame store: read this cycle, modify and write back next cycle
    // ------------------------------------------------------------------
    assign wr_en   = p_valid_reg && p_write_reg;
    assign wr_data = color_reg ? (rd_data | p_mask_reg) : (rd_data & ~p_mask_reg);

    pfde_ram #(
        .DATA_W (8),
        .DEPTH  (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (p_addr_reg),
        .wdata (wr_data),
        .re    (e_valid),
        .raddr (e_addr),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFDE_ASSERT_NOW(a_no_rmw_overlap, e_valid && wr_en, e_addr != p_addr_reg,
                     "read hits byte under write-back")
    `PFDE_ASSERT_NEXT(a_last_gives_word, state_reg == ST_LAST && !silent_reg, done_reg,
                      "command ended without a result word")
    `PFDE_ASSERT_NOW(a_word_from_last, done_reg, $past(state_reg == ST_LAST),
                     "result word outside a command end")
    `PFDE_ASSERT_NEXT(a_accept_runs, accept, state_reg == ST_RUN,
                      "accepted command did not start")
    `PFDE_ASSERT_NOW(a_clear_busy, silent_reg && state_reg == ST_RUN,
                     busy && mode_reg == MODE_FILL, "clearing pass not holding off commands")

endmodule
